// ----- hdl/lsce_pkg.sv -----
// Shared types and constants for the LS channel estimate and combine block.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lsce_pkg;

  // Item kinds on the input channel
  localparam logic [1:0] KIND_PILOT     = 2'd0;
  localparam logic [1:0] KIND_PILOT_SYM = 2'd1;
  localparam logic [1:0] KIND_DATA      = 2'd2;

  // Result kinds on the output channel
  localparam logic RES_POWER = 1'b0;
  localparam logic RES_DATA  = 1'b1;

  // Antenna count after reset
  localparam logic [4:0] ANT_USED_RESET = 5'd16;

  // Divider pipeline depth in register stages
  localparam int DIV_LAT = 18;

  // Quotient bits resolved by the restoring stages
  localparam int QUO_W = 15;

  typedef logic signed [15:0] smp_t;
  typedef logic signed [39:0] acc_t;

  // Sideband that travels with every item through the pipeline
  typedef struct packed {
    logic       v;      // stage holds a live item
    logic       psym;   // pilot-symbol item, otherwise data
    logic       first;  // antenna 0 starts the sum
    logic       last;   // last antenna in use emits the sum
    logic       zero;   // pilot power is zero
    logic [3:0] ant;
    logic [9:0] sc;
    smp_t       yr;
    smp_t       yi;
  } side_t;

endpackage

`default_nettype wire

// ----- hdl/lsce_in_if.sv -----
// Input channel of the LS channel estimate and combine block.
// Depends on lsce_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface lsce_in_if import lsce_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [3:0] antenna;
  logic [9:0] subcarrier;
  smp_t       sample_re;
  smp_t       sample_im;

  modport source (output valid, kind, antenna, subcarrier, sample_re, sample_im,
                  input ready);
  modport sink   (input valid, kind, antenna, subcarrier, sample_re, sample_im,
                  output ready);
endinterface

`default_nettype wire

// ----- hdl/lsce_out_if.sv -----
// Result channel of the LS channel estimate and combine block.
// Depends on lsce_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface lsce_out_if import lsce_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [9:0] out_subcarrier;
  logic       result_kind;
  acc_t       result_re;
  acc_t       result_im;

  modport source (output valid, out_subcarrier, result_kind, result_re, result_im,
                  input ready);
  modport sink   (input valid, out_subcarrier, result_kind, result_re, result_im,
                  output ready);
endinterface

`default_nettype wire

// ----- hdl/lsce_div.sv -----
// Pipelined restoring divider: round(num*4096/den), ties away from zero,
// saturated to 16 bits. One quotient bit per restoring stage. Depends on lsce_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lsce_div import lsce_pkg::*; (
  input  wire logic               clk,
  input  wire logic               en,
  input  wire logic signed [32:0] num,
  input  wire logic        [31:0] den,
  output      smp_t               quo
);

  typedef struct packed {
    logic [47:0]      rem;
    logic [47:0]      d2;
    logic [QUO_W-1:0] q;
    logic             neg;
    logic             ovf;
  } dst_t;

  logic        neg_r;
  logic [47:0] n_r;
  logic [47:0] d2_r;
  logic [32:0] mag;
  dst_t        st_r [QUO_W+1];
  smp_t        quo_r;

  function automatic dst_t div_step(dst_t s, int b);
    dst_t        o;
    logic [47:0] t;
    o = s;
    t = s.d2 << b;
    if (s.rem >= t) begin
      o.rem  = s.rem - t;
      o.q[b] = 1'b1;
    end
    return o;
  endfunction

  assign mag = num[32] ? 33'(-num) : 33'(num);

  always_ff @(posedge clk) begin
    if (en) begin
      // dividend is |num|*8192 + den against divisor 2*den
      neg_r <= num[32];
      n_r   <= (48'(mag[31:0]) << 13) + 48'(den);
      d2_r  <= 48'(den) << 1;

      st_r[0].rem <= n_r;
      st_r[0].d2  <= d2_r;
      st_r[0].q   <= '0;
      st_r[0].neg <= neg_r;
      st_r[0].ovf <= n_r >= (d2_r << QUO_W);

      for (int j = 0; j < QUO_W; j++) begin
        st_r[j+1] <= div_step(st_r[j], QUO_W - 1 - j);
      end

      if (st_r[QUO_W].ovf) begin
        quo_r <= st_r[QUO_W].neg ? 16'sh8000 : 16'sh7FFF;
      end else if (st_r[QUO_W].neg) begin
        quo_r <= 16'(16'd0 - 16'(st_r[QUO_W].q));
      end else begin
        quo_r <= 16'(st_r[QUO_W].q);
      end
    end
  end

  assign quo = quo_r;

endmodule

`default_nettype wire

// ----- hdl/ls_channel_estimate_and_combine.sv -----
// Least-squares channel estimation with maximum-ratio combining over antennas.
// Channels: in_ch (valid/ready) carries kind, antenna, subcarrier and a Q1.15
// sample; out_ch (valid/ready) carries one per-subcarrier sum when the last
// antenna in use arrives. cfg_we/cfg_wdata set the antennas in use (reset 16).
// A kind-0 beat loads the pilot for a subcarrier; a kind-1 beat computes
// conj(H) = conj(Y/X) in Q4.12, stores it and adds |H|^2 into the sum; a
// kind-2 beat adds Y*conj(H). Items out of range or of kind 3 make no result.
// Throughput: one beat per cycle, sustained while out_ch does not stall, on
// any pattern of subcarriers. Path to the result on out_ch: three stages of
// pilot read and products, 18 divider stages (one quotient bit per restoring
// stage), three stages of channel read, products and accumulation, and the
// output register; the first stage loads at the accepting edge itself.
// Read-modify-write of the sum store is forwarded from the previous write, so
// back-to-back beats to one subcarrier combine correctly.
// A stall on out_ch freezes the whole pipeline and in_ch.ready drops in the
// same cycle; nothing is lost or repeated. Reset empties the pipeline and sets
// the antenna count to 16; the pilot, channel and sum stores are not cleared
// and must be written before they are read.
`timescale 1ns / 1ps
`default_nettype none

module ls_channel_estimate_and_combine import lsce_pkg::*; #(
  parameter int MAX_ANTENNAS = 16,
  parameter int SUBCARRIERS  = 1024
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  lsce_in_if.sink         in_ch,
  lsce_out_if.source      out_ch,
  input  wire logic       cfg_we,
  input  wire logic [4:0] cfg_wdata
);

  localparam int SC_AW = $clog2(SUBCARRIERS);
  localparam int HC_AW = $clog2(MAX_ANTENNAS * SUBCARRIERS);

  // Stores
  logic [31:0] pilot_mem [SUBCARRIERS];
  logic [31:0] hc_mem    [MAX_ANTENNAS * SUBCARRIERS];
  logic [79:0] sum_mem   [SUBCARRIERS];

  logic [4:0]  ant_used_r;
  logic [31:0] used;
  logic        adv;
  logic        in_fire;

  // Accept stage
  logic [31:0]      in_sc32;
  logic [SC_AW-1:0] in_addr;
  logic             in_ok;
  side_t            s1_nxt;
  side_t            s1_r;
  logic [31:0]      pil_q_r;

  // Products against the pilot
  side_t             s2_r;
  logic signed [31:0] p_yrxr_r, p_yixi_r, p_yrxi_r, p_yixr_r, p_xrxr_r, p_xixi_r;
  smp_t              xr, xi;

  // Numerators and pilot power
  side_t              s3_nxt;
  side_t              s3_r;
  logic signed [32:0] num_re_r, num_im_r;
  logic        [31:0] den_r;
  logic signed [32:0] den_sum;

  // Divider delay line and outputs
  side_t       dl_r [DIV_LAT];
  side_t       sw;
  smp_t        dq_re, dq_im;
  smp_t        hr_w, hi_w;
  logic [31:0]      hc_idx32;
  logic [HC_AW-1:0] hc_idx;

  // Channel read and combine
  side_t        s4_r;
  smp_t         own_re_r, own_im_r;
  logic [31:0]  hc_q_r;
  smp_t         hr4, hi4, a4, b4;
  side_t        s5_r;
  logic signed [31:0] pa_r, pb_r, pc_r, pd_r;
  logic [31:0]      s5_sc32;
  logic [SC_AW-1:0] s5_addr;
  side_t        s6_r;
  logic signed [32:0] tr_r, ti_r;
  logic [79:0]  sum_q_r;
  logic [31:0]      s6_sc32;
  logic [SC_AW-1:0] s6_addr;
  acc_t         old_re, old_im, acc_re, acc_im;

  // Last sum written, for forwarding
  logic         lw_v_r;
  logic [9:0]   lw_sc_r;
  logic [79:0]  lw_data_r;

  // Output register
  logic         out_v_r;
  logic [9:0]   out_sc_r;
  logic         out_kind_r;
  acc_t         out_re_r, out_im_r;

  // Configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ant_used_r <= ANT_USED_RESET;
    end else if (cfg_we) begin
      ant_used_r <= cfg_wdata;
    end
  end

  always_comb begin
    if (ant_used_r == 5'd0) begin
      used = 32'd1;
    end else if (32'(ant_used_r) > 32'(MAX_ANTENNAS)) begin
      used = 32'(MAX_ANTENNAS);
    end else begin
      used = 32'(ant_used_r);
    end
  end

  // Whole pipeline advances unless a result waits on a stalled receiver
  assign adv         = !out_v_r || out_ch.ready;
  assign in_ch.ready = adv;
  assign in_fire     = in_ch.valid && adv;

  assign in_sc32 = 32'(in_ch.subcarrier);
  assign in_addr = in_sc32[SC_AW-1:0];
  assign in_ok   = (in_sc32 < 32'(SUBCARRIERS)) && (32'(in_ch.antenna) < used) &&
                   (in_ch.kind == KIND_PILOT_SYM || in_ch.kind == KIND_DATA);

  always_comb begin
    s1_nxt       = '0;
    s1_nxt.v     = in_fire && in_ok;
    s1_nxt.psym  = in_ch.kind == KIND_PILOT_SYM;
    s1_nxt.first = in_ch.antenna == 4'd0;
    s1_nxt.last  = 32'(in_ch.antenna) == used - 32'd1;
    s1_nxt.ant   = in_ch.antenna;
    s1_nxt.sc    = in_ch.subcarrier;
    s1_nxt.yr    = in_ch.sample_re;
    s1_nxt.yi    = in_ch.sample_im;
  end

  // Pilot store: write and read at the accepting edge keep program order
  always_ff @(posedge clk) begin
    if (adv) begin
      if (in_fire && in_ch.kind == KIND_PILOT && in_sc32 < 32'(SUBCARRIERS)) begin
        pilot_mem[in_addr] <= {in_ch.sample_re, in_ch.sample_im};
      end
      pil_q_r <= pilot_mem[in_addr];
    end
  end

  assign xr = pil_q_r[31:16];
  assign xi = pil_q_r[15:0];
  assign den_sum = p_xrxr_r + p_xixi_r;

  always_comb begin
    s3_nxt      = s2_r;
    s3_nxt.zero = den_sum == 33'sd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r <= '0;
      s2_r <= '0;
      s3_r <= '0;
    end else if (adv) begin
      s1_r <= s1_nxt;
      s2_r <= s1_r;
      s3_r <= s3_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p_yrxr_r <= s1_r.yr * xr;
      p_yixi_r <= s1_r.yi * xi;
      p_yrxi_r <= s1_r.yr * xi;
      p_yixr_r <= s1_r.yi * xr;
      p_xrxr_r <= xr * xr;
      p_xixi_r <= xi * xi;
      num_re_r <= p_yrxr_r + p_yixi_r;
      num_im_r <= p_yrxi_r - p_yixr_r;
      den_r    <= den_sum[31:0];
    end
  end

  lsce_div u_div_re (
    .clk (clk),
    .en  (adv),
    .num (num_re_r),
    .den (den_r),
    .quo (dq_re)
  );

  lsce_div u_div_im (
    .clk (clk),
    .en  (adv),
    .num (num_im_r),
    .den (den_r),
    .quo (dq_im)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < DIV_LAT; k++) begin
        dl_r[k] <= '0;
      end
    end else if (adv) begin
      dl_r[0] <= s3_r;
      for (int k = 1; k < DIV_LAT; k++) begin
        dl_r[k] <= dl_r[k-1];
      end
    end
  end

  assign sw       = dl_r[DIV_LAT-1];
  assign hr_w     = sw.zero ? 16'sd0 : dq_re;
  assign hi_w     = sw.zero ? 16'sd0 : dq_im;
  assign hc_idx32 = 32'(sw.ant) * 32'(SUBCARRIERS) + 32'(sw.sc);
  assign hc_idx   = hc_idx32[HC_AW-1:0];

  // Channel store: pilot-symbol writes and data reads share one stage
  always_ff @(posedge clk) begin
    if (adv) begin
      if (sw.v && sw.psym) begin
        hc_mem[hc_idx] <= {hr_w, hi_w};
      end
      hc_q_r   <= hc_mem[hc_idx];
      own_re_r <= hr_w;
      own_im_r <= hi_w;
    end
  end

  assign hr4 = s4_r.psym ? own_re_r : hc_q_r[31:16];
  assign hi4 = s4_r.psym ? own_im_r : hc_q_r[15:0];
  assign a4  = s4_r.psym ? hr4 : s4_r.yr;
  assign b4  = s4_r.psym ? hi4 : s4_r.yi;

  assign s5_sc32 = 32'(s5_r.sc);
  assign s5_addr = s5_sc32[SC_AW-1:0];
  assign s6_sc32 = 32'(s6_r.sc);
  assign s6_addr = s6_sc32[SC_AW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_r   <= '0;
      s5_r   <= '0;
      s6_r   <= '0;
      lw_v_r <= 1'b0;
    end else if (adv) begin
      s4_r   <= sw;
      s5_r   <= s4_r;
      s6_r   <= s5_r;
      lw_v_r <= s6_r.v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pa_r <= a4 * hr4;
      pb_r <= b4 * hi4;
      pc_r <= a4 * hi4;
      pd_r <= b4 * hr4;
      tr_r <= s5_r.psym ? 33'(pa_r + pb_r) : 33'(pa_r - pb_r);
      ti_r <= s5_r.psym ? 33'sd0 : 33'(pc_r + pd_r);
    end
  end

  // Forward the sum written at the same edge this item read the store
  always_comb begin
    if (lw_v_r && lw_sc_r == s6_r.sc) begin
      old_re = lw_data_r[79:40];
      old_im = lw_data_r[39:0];
    end else begin
      old_re = sum_q_r[79:40];
      old_im = sum_q_r[39:0];
    end
    if (s6_r.first) begin
      acc_re = 40'(tr_r);
      acc_im = 40'(ti_r);
    end else begin
      acc_re = old_re + 40'(tr_r);
      acc_im = old_im + 40'(ti_r);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sum_q_r <= sum_mem[s5_addr];
      if (s6_r.v) begin
        sum_mem[s6_addr] <= {acc_re, acc_im};
      end
      lw_sc_r   <= s6_r.sc;
      lw_data_r <= {acc_re, acc_im};
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= s6_r.v && s6_r.last;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_sc_r   <= s6_r.sc;
      out_kind_r <= s6_r.psym ? RES_POWER : RES_DATA;
      out_re_r   <= acc_re;
      out_im_r   <= acc_im;
    end
  end

  assign out_ch.valid          = out_v_r;
  assign out_ch.out_subcarrier = out_sc_r;
  assign out_ch.result_kind    = out_kind_r;
  assign out_ch.result_re      = out_re_r;
  assign out_ch.result_im      = out_im_r;

endmodule

`default_nettype wire
